FILE: hdl/crosshair_text_overlay_macros.svh
// Assertion macros for the crosshair and text overlay.
// Depends on nothing; included by the top level only.
`ifndef CROSSHAIR_TEXT_OVERLAY_MACROS_SVH
`define CROSSHAIR_TEXT_OVERLAY_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define CTO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define CTO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cto_pkg.sv
// Package for the crosshair and text overlay: screen geometry, font, codes
// and the hit-test functions. Depends on nothing.
package cto_pkg;

    // Screen and glyph geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int GLYPH_SCALE   = 2;

    localparam int ARM      = 24;
    localparam int GAP      = 6;
    localparam int THICK    = 2;
    localparam int ARM_LEN  = ARM - GAP;
    localparam int FONT_W   = 5;
    localparam int FONT_H   = 7;
    localparam int CHAR_GAP = 2;
    localparam int CHAR_ADV = FONT_W * GLYPH_SCALE + CHAR_GAP;
    localparam int MARGIN_X = 6;
    localparam int MARGIN_Y = 6;

    localparam int CX = SCREEN_WIDTH / 2;
    localparam int CY = SCREEN_HEIGHT / 2;
    localparam int X0 = CX - THICK / 2;
    localparam int Y0 = CY - THICK / 2;

    // Signed coordinate wide enough for every screen size and offset
    typedef logic signed [11:0] t_coord;

    localparam t_coord GLYPH_SCALE_C = t_coord'(GLYPH_SCALE);
    localparam t_coord GLYPH_W_C     = t_coord'(FONT_W * GLYPH_SCALE);
    localparam t_coord GLYPH_H_C     = t_coord'(FONT_H * GLYPH_SCALE);

    // Crosshair rectangles: upper, lower, left, right arm and center dot
    localparam int NUM_RECTS = 5;
    localparam int RECT_X [NUM_RECTS] = '{X0, X0, CX - ARM, CX + GAP, X0};
    localparam int RECT_Y [NUM_RECTS] = '{CY - ARM, CY + GAP, Y0, Y0, Y0};
    localparam int RECT_W [NUM_RECTS] = '{THICK, THICK, ARM_LEN, ARM_LEN, THICK};
    localparam int RECT_H [NUM_RECTS] = '{ARM_LEN, ARM_LEN, THICK, THICK, THICK};

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FPS_MAX = 14'd9999;

    // Reciprocal constants for the decimal split of a 14-bit value
    localparam logic [29:0] DIV10_MUL   = 30'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [29:0] DIV100_MUL  = 30'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [29:0] DIV1K_MUL   = 30'd8389;
    localparam int          DIV1K_SHIFT = 23;

    // Character codes: 0..9 are digits
    typedef logic [3:0] t_code;
    localparam t_code CODE_9     = 4'd9;
    localparam t_code CODE_DOT   = 4'd10;
    localparam t_code CODE_F     = 4'd11;
    localparam t_code CODE_P     = 4'd12;
    localparam t_code CODE_S     = 4'd13;
    localparam t_code CODE_SPACE = 4'd14;
    localparam t_code CODE_NONE  = 4'd15;

    // Text slots counted from the right edge; slot 0 is the tenths digit
    localparam int NUM_SLOTS = 9;
    typedef logic [NUM_SLOTS-1:0][3:0] t_slots;
    localparam int SLOT_X0 = SCREEN_WIDTH - MARGIN_X - CHAR_ADV + CHAR_GAP;

    localparam logic [6:0] FONT_BITS [14][FONT_W] = '{
        '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
        '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
        '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46},
        '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
        '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
        '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30},
        '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
        '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00},
        '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
        '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
        '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}
    };

    localparam logic [15:0] COLOR_BLACK = 16'h0000;
    localparam logic [15:0] COLOR_WHITE = 16'hFFFF;

    function automatic logic [15:0] mode_color(input logic [1:0] mode);
        logic [15:0] color;
        case (mode)
            2'd0:    color = 16'h07E0;
            2'd1:    color = 16'hFFE0;
            2'd2:    color = 16'hF800;
            default: color = 16'h07FF;
        endcase
        return color;
    endfunction

    function automatic logic [6:0] font_col(input t_code code, input logic [2:0] col);
        logic [6:0] bits;
        bits = 7'h00;
        if (code < CODE_SPACE && col < 3'(FONT_W)) begin
            bits = FONT_BITS[code][col];
        end
        return bits;
    endfunction

    function automatic logic in_rect(input t_coord c, input t_coord r, input int x,
                                     input int y, input int w, input int h, input int g);
        t_coord x0;
        t_coord y0;
        x0 = t_coord'(x - g);
        y0 = t_coord'(y - g);
        return (c >= x0) && (c < x0 + t_coord'(w + 2 * g)) &&
               (r >= y0) && (r < y0 + t_coord'(h + 2 * g));
    endfunction

    function automatic logic in_cross(input t_coord c, input t_coord r, input int g);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NUM_RECTS; k++) begin
            hit = hit | in_rect(c, r, RECT_X[k], RECT_Y[k], RECT_W[k], RECT_H[k], g);
        end
        return hit;
    endfunction

    function automatic logic in_text(input t_coord c, input t_coord r, input t_coord off,
                                     input t_slots codes);
        logic       hit;
        t_coord     dc;
        t_coord     dr;
        logic [2:0] fcol;
        logic [2:0] frow;
        logic [6:0] bits;
        hit  = 1'b0;
        dr   = r - t_coord'(MARGIN_Y) - off;
        frow = 3'(dr / GLYPH_SCALE_C);
        if (dr >= 0 && dr < GLYPH_H_C) begin
            for (int j = 0; j < NUM_SLOTS; j++) begin
                dc   = c - t_coord'(SLOT_X0 - j * CHAR_ADV) - off;
                fcol = 3'(dc / GLYPH_SCALE_C);
                bits = font_col(codes[j], fcol);
                if (dc >= 0 && dc < GLYPH_W_C && bits[frow]) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // Lay out "FPS w.t" right aligned; ndig is the count of whole digits
    function automatic t_slots build_slots(input t_code hund, input t_code tens,
                                           input t_code ones, input t_code tenth,
                                           input logic [1:0] ndig);
        t_slots s;
        s    = {NUM_SLOTS{CODE_NONE}};
        s[0] = tenth;
        s[1] = CODE_DOT;
        s[2] = ones;
        case (ndig)
            2'd3: begin
                s[3] = tens;
                s[4] = hund;
                s[5] = CODE_SPACE;
                s[6] = CODE_S;
                s[7] = CODE_P;
                s[8] = CODE_F;
            end
            2'd2: begin
                s[3] = tens;
                s[4] = CODE_SPACE;
                s[5] = CODE_S;
                s[6] = CODE_P;
                s[7] = CODE_F;
            end
            default: begin
                s[3] = CODE_SPACE;
                s[4] = CODE_S;
                s[5] = CODE_P;
                s[6] = CODE_F;
            end
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/crosshair_text_overlay.sv
// Top level of the crosshair and frame-rate text overlay for an RGB565 stream.
// Depends on cto_pkg and crosshair_text_overlay_macros.svh.

// Takes one pixel per clock (start high; busy is always low, so every start is
// taken) and returns it with the overlay applied on o_pixel_out. A one-cycle
// o_valid strobe marks each result as it leaves the result register, after the
// input register and the hit tests. The result cannot be held off:
// read it in the cycle o_valid is high. Throughput is one item per clock, set
// by the input register and the result register with the crosshair and text
// hit tests between them. A frame-rate write is split into decimal digits as it
// is written, so an item taken at or after the write edge already sees the new
// text. There is no clearing pass after reset.
module crosshair_text_overlay (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [8:0]                      i_column,
    input  logic [7:0]                      i_row,
    input  logic [15:0]                     i_pixel_in,
    output logic                            o_valid,
    output logic [15:0]                     o_pixel_out,
    input  logic                            i_cfg_we,
    input  logic [cto_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cto_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import cto_pkg::*;

    `include "crosshair_text_overlay_macros.svh"

    // Configuration registers
    logic   r_enable;
    logic   [1:0] r_mode;
    t_slots r_slot_code;
    t_slots n_slot_code;

    // Input register
    logic        r_in_valid;
    logic [8:0]  r_col;
    logic [7:0]  r_row;
    logic [15:0] r_pix;

    // Result register
    logic        r_valid;
    logic [15:0] r_pixel_out;
    logic [15:0] n_pixel_out;

    logic accept;

    // Never stall the source: a new item enters every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Split the written frame rate into digits by reciprocal multiplication
    always_comb begin
        logic [29:0] p10;
        logic [29:0] p100;
        logic [29:0] p1k;
        logic [10:0] q10;
        logic [7:0]  q100;
        logic [4:0]  q1k;
        t_code       tenth;
        t_code       ones;
        t_code       tens;
        t_code       hund;
        logic [1:0]  ndig;
        p10   = 30'(i_cfg_wdata) * DIV10_MUL;
        p100  = 30'(i_cfg_wdata) * DIV100_MUL;
        p1k   = 30'(i_cfg_wdata) * DIV1K_MUL;
        q10   = 11'(p10 >> DIV10_SHIFT);
        q100  = 8'(p100 >> DIV100_SHIFT);
        q1k   = 5'(p1k >> DIV1K_SHIFT);
        tenth = 4'(i_cfg_wdata - 14'({q10, 3'b000}) - 14'({q10, 1'b0}));
        ones  = 4'(q10 - 11'({q100, 3'b000}) - 11'({q100, 1'b0}));
        tens  = 4'(q100 - 8'({q1k, 3'b000}) - 8'({q1k, 1'b0}));
        hund  = 4'(q1k);
        ndig  = (q1k != 5'd0) ? 2'd3 : ((q100 != 8'd0) ? 2'd2 : 2'd1);
        // Saturate: anything above the limit reads 999.9
        if (i_cfg_wdata > FPS_MAX) begin
            n_slot_code = build_slots(CODE_9, CODE_9, CODE_9, CODE_9, 2'd3);
        end else begin
            n_slot_code = build_slots(hund, tens, ones, tenth, ndig);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_mode      <= 2'd0;
            r_slot_code <= build_slots(4'd0, 4'd0, 4'd0, 4'd0, 2'd1);
        end else if (i_cfg_we) begin
            // Drop writes to an unused index
            case (i_cfg_idx)
                CFG_ENABLE: r_enable    <= i_cfg_wdata[0];
                CFG_MODE:   r_mode      <= i_cfg_wdata[1:0];
                CFG_FPS:    r_slot_code <= n_slot_code;
                default:    ;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= i_column;
            r_row <= i_row;
            r_pix <= i_pixel_in;
        end
    end

    // Paint in layer order: outline, fill, shadow, text; later layers win
    always_comb begin
        t_coord c;
        t_coord r;
        logic   on_screen;
        c           = t_coord'({3'b000, r_col});
        r           = t_coord'({4'b0000, r_row});
        on_screen   = (c < t_coord'(SCREEN_WIDTH)) && (r < t_coord'(SCREEN_HEIGHT));
        n_pixel_out = r_pix;
        if (r_enable && on_screen) begin
            if (in_cross(c, r, 1)) begin
                n_pixel_out = COLOR_BLACK;
            end
            if (in_cross(c, r, 0)) begin
                n_pixel_out = mode_color(r_mode);
            end
            if (in_text(c, r, t_coord'(1), r_slot_code)) begin
                n_pixel_out = COLOR_BLACK;
            end
            if (in_text(c, r, t_coord'(0), r_slot_code)) begin
                n_pixel_out = COLOR_WHITE;
            end
        end
    end

    // Register the result and raise the strobe with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_pixel_out <= n_pixel_out;
        end
    end

    assign o_valid     = r_valid;
    assign o_pixel_out = r_pixel_out;

    // Pass the pixel through untouched while the overlay is off
    `CTO_ASSERT_NEXT(a_disabled_pass, i_clk, i_rst_n,
        r_in_valid && !r_enable,
        r_pixel_out == $past(r_pix),
        "overlay disabled but pixel changed")
    // Pass off-screen pixels through untouched
    `CTO_ASSERT_NEXT(a_offscreen_pass, i_clk, i_rst_n,
        r_in_valid && (({3'b000, r_col} >= 12'(SCREEN_WIDTH)) ||
                       ({4'b0000, r_row} >= 12'(SCREEN_HEIGHT))),
        r_pixel_out == $past(r_pix),
        "off-screen pixel changed")
    // Show a saturated frame rate as 999.9; the tenths, ones and hundreds slots are checked
    `CTO_ASSERT_NEXT(a_fps_saturate, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_idx == CFG_FPS) && (i_cfg_wdata > FPS_MAX),
        (r_slot_code[0] == CODE_9) && (r_slot_code[2] == CODE_9) &&
            (r_slot_code[4] == CODE_9),
        "saturated frame rate not shown as 999.9")
    // Keep the tenths slot a decimal digit
    `CTO_ASSERT_NOW(a_tenth_digit, i_clk, i_rst_n,
        r_slot_code[1] == CODE_DOT,
        r_slot_code[0] <= CODE_9,
        "tenths slot holds a non-digit")

endmodule

FILE: bench/crosshair_text_overlay_tb.sv
// Self-checking testbench for crosshair_text_overlay: drives pixels and register
// writes, predicts every overlaid pixel and checks each o_valid result in order.
// Depends on cto_pkg and the crosshair_text_overlay RTL.
module crosshair_text_overlay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cto_pkg::*;

    // The fourth register index has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Cycles to let pass after the last expected pixel before touching registers
    localparam int SETTLE_CYCLES = 4;
    // Hard stop for the whole run, well above the slowest legal run
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        int unsigned col;
        int unsigned row;
        logic [15:0] pixel;
    } t_pixel_expect;

    // Predicts the overlaid pixel for every taken item and checks results in order
    class PixelScoreboard;
        localparam int SCR_W = 320;
        localparam int SCR_H = 240;
        localparam int SCALE = 2;
        localparam int GLYPH_W = 5;
        localparam int GLYPH_H = 7;
        localparam int ADV   = GLYPH_W * SCALE + 2;
        localparam int MID_X = SCR_W / 2;
        localparam int MID_Y = SCR_H / 2;
        localparam logic [0:13][0:4][6:0] GLYPH_BITS = {
            7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E,
            7'h00, 7'h42, 7'h7F, 7'h40, 7'h00,
            7'h42, 7'h61, 7'h51, 7'h49, 7'h46,
            7'h21, 7'h41, 7'h45, 7'h4B, 7'h31,
            7'h18, 7'h14, 7'h12, 7'h7F, 7'h10,
            7'h27, 7'h45, 7'h45, 7'h45, 7'h39,
            7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30,
            7'h01, 7'h71, 7'h09, 7'h05, 7'h03,
            7'h36, 7'h49, 7'h49, 7'h49, 7'h36,
            7'h06, 7'h49, 7'h49, 7'h29, 7'h1E,
            7'h00, 7'h60, 7'h60, 7'h00, 7'h00,
            7'h7F, 7'h09, 7'h09, 7'h09, 7'h01,
            7'h7F, 7'h09, 7'h09, 7'h09, 7'h06,
            7'h46, 7'h49, 7'h49, 7'h49, 7'h31
        };
        localparam logic [0:3][15:0] TRACK_COLOR = {16'h07E0, 16'hFFE0, 16'hF800, 16'h07FF};

        bit            enable;
        logic [1:0]    mode;
        logic [13:0]   fps;
        int            fails;
        t_pixel_expect pending[$];

        function new();
            enable = 1'b1;
            mode   = 2'd0;
            fps    = 14'd0;
            fails  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ENABLE) begin
                enable = data[0];
            end else if (idx == CFG_MODE) begin
                mode = data[1:0];
            end else if (idx == CFG_FPS) begin
                fps = data;
            end
        endfunction

        function bit in_box(int c, int r, int x, int y, int w, int h, int g);
            return c >= x - g && c < x + w + g && r >= y - g && r < y + h + g;
        endfunction

        // Two-pixel-thick arms from 6 to 24 pixels out, plus the 2x2 dot
        function bit on_cross(int c, int r, int g);
            return in_box(c, r, MID_X - 1, MID_Y - 24, 2, 18, g) ||
                   in_box(c, r, MID_X - 1, MID_Y + 6, 2, 18, g) ||
                   in_box(c, r, MID_X - 24, MID_Y - 1, 18, 2, g) ||
                   in_box(c, r, MID_X + 6, MID_Y - 1, 18, 2, g) ||
                   in_box(c, r, MID_X - 1, MID_Y - 1, 2, 2, g);
        endfunction

        function bit on_text(int c, int r, int tx, int ty, int codes[9], int n);
            int frow;
            int dc;
            if (r < ty) return 1'b0;
            frow = (r - ty) / SCALE;
            if (frow >= GLYPH_H) return 1'b0;
            for (int i = 0; i < n; i++) begin
                if (codes[i] >= int'(CODE_SPACE)) continue;
                dc = c - (tx + i * ADV);
                if (dc < 0 || dc >= GLYPH_W * SCALE) continue;
                if (GLYPH_BITS[codes[i]][dc / SCALE][frow]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [15:0] overlay_pixel(int c, int r, logic [15:0] pix);
            logic [15:0] p;
            int          codes[9];
            int          n;
            int          shown;
            int          whole;
            int          tx;
            p = pix;
            if (enable && c < SCR_W && r < SCR_H) begin
                if (on_cross(c, r, 1)) p = 16'h0000;
                if (on_cross(c, r, 0)) p = TRACK_COLOR[mode];
                shown = (fps > FPS_MAX) ? int'(FPS_MAX) : int'(fps);
                whole = shown / 10;
                foreach (codes[k]) codes[k] = int'(CODE_SPACE);
                codes[0] = int'(CODE_F);
                codes[1] = int'(CODE_P);
                codes[2] = int'(CODE_S);
                n = 4;
                if (whole >= 100) begin
                    codes[n] = whole / 100;
                    n++;
                end
                if (whole >= 10) begin
                    codes[n] = (whole / 10) % 10;
                    n++;
                end
                codes[n]     = whole % 10;
                codes[n + 1] = int'(CODE_DOT);
                codes[n + 2] = shown % 10;
                n += 3;
                tx = SCR_W - 6 - (n * ADV - 2);
                if (on_text(c, r, tx + 1, 7, codes, n)) p = 16'h0000;
                if (on_text(c, r, tx, 6, codes, n)) p = 16'hFFFF;
            end
            return p;
        endfunction

        function void note_pixel(logic [8:0] col, logic [7:0] row, logic [15:0] pix);
            t_pixel_expect e;
            e.col   = col;
            e.row   = row;
            e.pixel = overlay_pixel(int'(col), int'(row), pix);
            pending.push_back(e);
        endfunction

        function void check_pixel(logic [15:0] actual);
            t_pixel_expect e;
            if (pending.size() == 0) begin
                $display("%0t: pixel %h arrived with none pending (expected none, actual %h)",
                         $time, actual, actual);
                fails++;
            end else begin
                e = pending.pop_front();
                if (e.pixel !== actual) begin
                    $display("%0t: pixel at col %0d row %0d: expected %h, actual %h",
                             $time, e.col, e.row, e.pixel, actual);
                    fails++;
                end
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [8:0]            i_column;
    logic [7:0]            i_row;
    logic [15:0]           i_pixel_in;
    logic                  o_valid;
    logic [15:0]           o_pixel_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    PixelScoreboard sb = new();
    int             cycle_count = 0;

    crosshair_text_overlay DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop the run if it hangs well past the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Results cannot be held off: take every strobed pixel at the edge ending its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_pixel(o_pixel_out);
        end
    end

    // Present one item and hold it until the block takes it; start stays high
    // afterwards so a back-to-back item needs no toggle
    task automatic send_pixel(input logic [8:0] c, input logic [7:0] r, input logic [15:0] p);
        start      <= 1'b1;
        i_column   <= c;
        i_row      <= r;
        i_pixel_in <= p;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(c, r, p);
    endtask

    // Drop start for a random gap: mostly none or short, now and then long
    task automatic pixel_gap(input bit burst);
        int pick;
        int cycles;
        pick   = $urandom_range(0, 99);
        cycles = 0;
        if (!burst) begin
            if (pick >= 85) begin
                cycles = $urandom_range(10, 40);
            end else if (pick >= 50) begin
                cycles = $urandom_range(1, 3);
            end
        end
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Wait until every pending pixel is back, then let the pipeline settle
    task automatic drain_pixels();
        start <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four indexes back to back, junk in the unused bits, write enable
    // held high across the burst
    task automatic load_registers(input bit en, input logic [1:0] mode,
                                  input logic [CFG_DATA_W-1:0] fps);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] data[4];
        idx[0]  = CFG_ENABLE;
        data[0] = {13'($urandom), en};
        idx[1]  = CFG_MODE;
        data[1] = {12'($urandom), mode};
        idx[2]  = CFG_FPS;
        data[2] = fps;
        idx[3]  = CFG_UNUSED;
        data[3] = 14'($urandom);
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            i_cfg_idx   <= idx[k];
            i_cfg_wdata <= data[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], data[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Aim most pixels at the crosshair and the text, the rest anywhere the fields allow
    task automatic random_pixel();
        int          region;
        logic [8:0]  c;
        logic [7:0]  r;
        region = $urandom_range(0, 9);
        if (region <= 3) begin
            c = 9'($urandom_range(130, 190));
            r = 8'($urandom_range(90, 150));
        end else if (region <= 6) begin
            c = 9'($urandom_range(200, 319));
            r = 8'($urandom_range(0, 24));
        end else if (region == 7) begin
            c = 9'($urandom);
            r = 8'($urandom);
        end else if (region == 8) begin
            c = 9'($urandom_range(310, 330));
            r = 8'($urandom_range(230, 245));
        end else begin
            c = 9'($urandom_range(0, 319));
            r = 8'($urandom_range(0, 239));
        end
        send_pixel(c, r, 16'($urandom));
    endtask

    // One register setting, then a stream of random pixels under it
    task automatic run_phase(input bit en, input logic [1:0] mode,
                             input logic [CFG_DATA_W-1:0] fps, input int count);
        bit burst;
        load_registers(en, mode, fps);
        burst = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            random_pixel();
            pixel_gap(burst);
        end
        drain_pixels();
    endtask

    initial begin
        start       <= 1'b0;
        i_column    <= '0;
        i_row       <= '0;
        i_pixel_in  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset setting: text reads "FPS 0.0"
        send_pixel(9'd0, 8'd0, 16'hFFFF);       pixel_gap(1'b0);
        send_pixel(9'd319, 8'd239, 16'h0000);   pixel_gap(1'b0);
        send_pixel(9'd320, 8'd0, 16'hA5A5);     pixel_gap(1'b0);  // first column off screen
        send_pixel(9'd0, 8'd240, 16'h5A5A);     pixel_gap(1'b0);  // first row off screen
        send_pixel(9'd511, 8'd255, 16'hFFFF);   pixel_gap(1'b0);
        send_pixel(9'd160, 8'd120, 16'h1234);   pixel_gap(1'b0);  // center dot
        send_pixel(9'd158, 8'd95, 16'hFFFF);    pixel_gap(1'b0);  // outline corner
        send_pixel(9'd159, 8'd96, 16'h0000);    pixel_gap(1'b0);  // upper arm tip
        send_pixel(9'd160, 8'd113, 16'hFFFF);   pixel_gap(1'b0);  // upper arm inner end
        send_pixel(9'd160, 8'd117, 16'hFFFF);   pixel_gap(1'b0);  // gap between arm and dot
        send_pixel(9'd136, 8'd119, 16'h0000);   pixel_gap(1'b0);  // left arm tip
        send_pixel(9'd183, 8'd120, 16'hFFFF);   pixel_gap(1'b0);  // right arm tip
        send_pixel(9'd184, 8'd121, 16'hFFFF);   pixel_gap(1'b0);  // right arm outline
        send_pixel(9'd159, 8'd143, 16'h0000);   pixel_gap(1'b0);  // lower arm tip
        send_pixel(9'd232, 8'd6, 16'h0000);     pixel_gap(1'b0);  // top of the F
        send_pixel(9'd242, 8'd7, 16'hFFFF);     pixel_gap(1'b0);  // F shadow
        send_pixel(9'd270, 8'd10, 16'h0000);    pixel_gap(1'b0);  // space character
        send_pixel(9'd231, 8'd6, 16'h0000);     pixel_gap(1'b0);  // just left of the text
        send_pixel(9'd314, 8'd19, 16'h0000);    pixel_gap(1'b0);  // just right of the text's bottom-right corner
        send_pixel(9'd315, 8'd20, 16'h0000);    pixel_gap(1'b0);  // just right of the shadow's bottom-right corner
        send_pixel(9'd256, 8'd128, 16'h8001);   pixel_gap(1'b0);
        drain_pixels();

        // Register settings: every color, blank display, digit counts and clamp
        run_phase(1'b1, 2'd0, 14'd0, 50);
        run_phase(1'b1, 2'd1, 14'd9999, 50);
        run_phase(1'b1, 2'd2, 14'd16383, 50);   // shown as the clamped maximum
        run_phase(1'b0, 2'd3, 14'd1234, 40);    // overlay off: pixels pass through
        run_phase(1'b1, 2'd3, 14'd5, 50);
        run_phase(1'b1, 2'd0, 14'd99, 50);
        run_phase(1'b1, 2'd1, 14'd100, 50);
        run_phase(1'b1, 2'd2, 14'd999, 50);
        run_phase(1'b1, 2'd3, 14'd1000, 50);
        repeat (3) begin
            run_phase($urandom_range(0, 4) != 0, 2'($urandom),
                      $urandom_range(0, 1) ? 14'($urandom) : 14'($urandom_range(0, 99)), 40);
        end

        if (sb.fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cto_pkg.sv
hdl/crosshair_text_overlay.sv
bench/crosshair_text_overlay_tb.sv
